// ===== rtl/core/multiband_noise_gate_gain_unit_defines.svh =====
// ---------------------------------------------------------------------------
// multiband noise gate gain unit: assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef MULTIBAND_NOISE_GATE_GAIN_UNIT_DEFINES_SVH
`define MULTIBAND_NOISE_GATE_GAIN_UNIT_DEFINES_SVH

// same-cycle implication
`define MNGG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mngg: same-cycle check failed");

// next-cycle implication
`define MNGG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mngg: next-cycle check failed");

`endif

// ===== rtl/core/mngg_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mngg_pkg
// types, constants and the gain lookup table of the noise gate gain unit
// ---------------------------------------------------------------------------
package mngg_pkg;

  localparam int MAX_BANDS        = 64;
  localparam int BAND_W           = $clog2(MAX_BANDS);
  localparam int GAIN_TABLE_DEPTH = 1024;
  localparam int IDX_W            = $clog2(GAIN_TABLE_DEPTH);
  localparam int CFG_ADDR_W       = 5;

  localparam logic [31:0]        GAIN_STEP_Q32 = 32'd4233600378;
  localparam logic signed [17:0] FLOOR_RESET   = -18'sd25600;
  localparam logic [15:0]        UNITY_GAIN    = 16'd32768;
  localparam logic [16:0]        Q16_ONE       = 17'd65536;
  localparam logic signed [19:0] RAMP_Q8       = 20'sd1536;
  localparam logic [14:0]        RED_MAX       = 15'd30720;

  // register reset values
  localparam logic [6:0]         NUM_BANDS_RST = 7'd64;
  localparam logic signed [14:0] THRESH_RST    = 15'sd1536;
  localparam logic signed [15:0] REDUCT_RST    = -16'sd5120;
  localparam logic [16:0]        ALPHA_RST     = 17'd62259;
  localparam logic [16:0]        ATTACK_RST    = 17'd52429;
  localparam logic [16:0]        RELEASE_RST   = 17'd62259;

  typedef enum logic [2:0] {
    REG_NUM_BANDS = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_REDUCTION = 3'd2,
    REG_ALPHA     = 3'd3,
    REG_ATTACK    = 3'd4,
    REG_RELEASE   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [6:0]         num_bands;
    logic signed [14:0] threshold_db;
    logic signed [15:0] reduction_db;
    logic [16:0]        noise_alpha;
    logic [16:0]        attack_coeff;
    logic [16:0]        release_coeff;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_FLR,
    S_TGT,
    S_RAMP,
    S_DIV,
    S_LUT,
    S_SMOOTH,
    S_WB
  } seq_state_t;

  typedef logic [15:0] gain_tab_t [GAIN_TABLE_DEPTH];

  // 10^(-i/160) in q1.15, built by repeated q32 multiplication
  function automatic gain_tab_t build_gain_table();
    gain_tab_t   tab;
    logic [63:0] g;
    g = 64'd1 << 30;
    for (int i = 0; i < GAIN_TABLE_DEPTH; i++) begin
      tab[i] = 16'((g + 64'd16384) >> 15);
      g = (g * {32'd0, GAIN_STEP_Q32} + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam gain_tab_t GAIN_TABLE = build_gain_table();

endpackage

// ===== rtl/core/multiband_noise_gate_gain_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multiband_noise_gate_gain_unit
// per-band noise floor tracking and smoothed gate gain, state held in two
// 64-entry rams (floor and gain) updated by read-modify-write
// ---------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  in       | in_valid / in_stall      | in_mode, in_band_index, in_energy_db
//  out      | out_valid / out_stall    | out_band_out, out_gate_gain,
//           |                          | out_noise_floor_out, out_band_error
//  cfg      | psel, penable, pwrite    | paddr, pwdata, prdata, pready
//
//  process-mode item: the sequencer walks ram read, floor multiply, floor
//   sum, ramp multiply, divide by three, table lookup, smoothing multiply
//   and write-back one step a cycle, then returns to idle for the next accept
//  learn-mode and out-of-range items: read, write-back, idle
//  reset (rst_n low, synchronous) marks every band as unwritten; such a band
//   reads as floor -100 dB and unity gain, so no clearing pass is needed
//  a stalled output holds the sequencer in write-back; the result register
//   lets the next item be taken while the previous one waits on out_stall
// ---------------------------------------------------------------------------
`include "multiband_noise_gate_gain_unit_defines.svh"

module multiband_noise_gate_gain_unit
  import mngg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // input items
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_mode,
  input  logic [BAND_W-1:0]        in_band_index,
  input  logic signed [17:0]       in_energy_db,
  // result items
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [BAND_W-1:0]        out_band_out,
  output logic [15:0]              out_gate_gain,
  output logic signed [17:0]       out_noise_floor_out,
  output logic                     out_band_error,
  // register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  cfg_t cfg;

  mngg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  seq_state_t state_r, state_nxt;
  logic       accept;
  logic       out_load;
  logic       ram_we;

  // item registers
  logic                  mode_r;
  logic [BAND_W-1:0]     band_r;
  logic signed [17:0]    energy_r;
  logic                  err_r;

  // datapath registers
  logic signed [17:0]    floor_old_r;
  logic [15:0]           gain_old_r;
  logic signed [36:0]    fprod_r;
  logic signed [17:0]    fl_new_r;
  logic [25:0]           rprod_r;
  logic                  gated_r;
  logic [IDX_W-1:0]      idx_r;
  logic [15:0]           target_r;
  logic signed [34:0]    sprod_r;

  // written-band flags, cleared by reset
  logic [MAX_BANDS-1:0]  valid_r, valid_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic [BAND_W-1:0]     out_band_r;
  logic [15:0]           out_gain_r;
  logic signed [17:0]    out_floor_r;
  logic                  out_band_error_r;

  // ram ports
  logic [17:0]           floor_rdata;
  logic [15:0]           gain_rdata;
  logic signed [17:0]    wb_floor;
  logic [15:0]           wb_gain;

  // ---- combinational datapath ----
  logic [16:0]           alpha_c;
  logic [16:0]           beta;
  logic signed [18:0]    fdiff;
  logic signed [36:0]    fround;
  logic [18:0]           fl_sum;
  logic signed [19:0]    d_w;
  logic [10:0]           d_cl;
  logic signed [16:0]    red_neg;
  logic [14:0]           red_mag;
  logic [25:0]           ramp_round;
  logic [11:0]           q_in;
  logic [27:0]           q_prod;
  logic [10:0]           q_div3;
  logic [16:0]           c_raw;
  logic [16:0]           c_cl;
  logic signed [16:0]    gdiff;
  logic signed [34:0]    sround;
  logic [16:0]           g_sum;

  // floor update: floor + ((65536-alpha)*(energy-floor) + half) >> 16
  assign alpha_c = (cfg.noise_alpha > Q16_ONE) ? Q16_ONE : cfg.noise_alpha;
  assign beta    = Q16_ONE - alpha_c;
  assign fdiff   = {energy_r[17], energy_r} - {floor_old_r[17], floor_old_r};
  assign fround  = fprod_r + 37'sd32768;
  assign fl_sum  = {floor_old_r[17], floor_old_r} + fround[34:16];

  // distance below floor + threshold, clamped to the 6 dB ramp
  assign d_w  = {{2{fl_new_r[17]}}, fl_new_r}
              + {{5{cfg.threshold_db[14]}}, cfg.threshold_db}
              - {{2{energy_r[17]}}, energy_r};
  assign d_cl = (d_w > RAMP_Q8) ? RAMP_Q8[10:0] : d_w[10:0];

  // reduction magnitude clamped to 0..120 dB
  assign red_neg = -{cfg.reduction_db[15], cfg.reduction_db};
  always_comb begin
    priority if (cfg.reduction_db > 16'sd0) begin
      red_mag = '0;
    end else if (red_neg > signed'({2'b00, RED_MAX})) begin
      red_mag = RED_MAX;
    end else begin
      red_mag = red_neg[14:0];
    end
  end

  // table index = (r*d + 24576) / 49152 as (>>14) then exact divide by 3
  assign ramp_round = rprod_r + 26'd24576;
  assign q_in       = ramp_round[25:14];
  assign q_prod     = q_in * 16'd43691;
  assign q_div3     = q_prod[27:17];

  // smoothing: target + (c*(gain-target) + half) >> 16
  assign c_raw  = (target_r < gain_old_r) ? cfg.attack_coeff : cfg.release_coeff;
  assign c_cl   = (c_raw > Q16_ONE) ? Q16_ONE : c_raw;
  assign gdiff  = {1'b0, gain_old_r} - {1'b0, target_r};
  assign sround = sprod_r + 35'sd32768;
  assign g_sum  = {1'b0, target_r} + sround[32:16];

  // write-back values
  always_comb begin
    if (mode_r) begin
      wb_floor = energy_r;
      wb_gain  = gain_old_r;
    end else begin
      wb_floor = fl_new_r;
      wb_gain  = g_sum[15:0];
    end
  end

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_RD;
      S_RD:     state_nxt = (err_r || mode_r) ? S_WB : S_FLR;
      S_FLR:    state_nxt = S_TGT;
      S_TGT:    state_nxt = S_RAMP;
      S_RAMP:   state_nxt = S_DIV;
      S_DIV:    state_nxt = S_LUT;
      S_LUT:    state_nxt = S_SMOOTH;
      S_SMOOTH: state_nxt = S_WB;
      S_WB:     if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // ---- sequencer outputs ----
  always_comb begin
    in_stall = (state_r != S_IDLE);
    out_load = (state_r == S_WB) && (!out_valid_r || !out_stall);
    ram_we   = out_load && !err_r;
  end

  assign accept = in_valid && !in_stall;

  // written-band flags and output handshake
  always_comb begin
    valid_nxt = valid_r;
    if (ram_we) begin
      valid_nxt[band_r] = 1'b1;
    end
  end

  always_comb begin
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // ---- state memories ----
  mngg_ram #(.WIDTH(18), .DEPTH(MAX_BANDS)) u_floor_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (band_r),
    .wdata (wb_floor),
    .re    (accept),
    .raddr (in_band_index),
    .rdata (floor_rdata)
  );

  mngg_ram #(.WIDTH(16), .DEPTH(MAX_BANDS)) u_gain_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (band_r),
    .wdata (wb_gain),
    .re    (accept),
    .raddr (in_band_index),
    .rdata (gain_rdata)
  );

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= in_mode;
      band_r   <= in_band_index;
      energy_r <= in_energy_db;
      // band beyond the bands in use
      err_r    <= ({1'b0, in_band_index} >= cfg.num_bands);
    end

    unique case (state_r)
      S_RD: begin
        // unwritten band reads as its reset value
        floor_old_r <= valid_r[band_r] ? signed'(floor_rdata) : FLOOR_RESET;
        gain_old_r  <= valid_r[band_r] ? gain_rdata : UNITY_GAIN;
      end
      S_FLR:    fprod_r  <= signed'({1'b0, beta}) * fdiff;
      S_TGT:    fl_new_r <= signed'(fl_sum[17:0]);
      S_RAMP: begin
        rprod_r <= red_mag * d_cl;
        gated_r <= d_w[19] || (d_w == 20'sd0);
      end
      S_DIV:    idx_r    <= (q_div3 > 11'(GAIN_TABLE_DEPTH - 1))
                            ? IDX_W'(GAIN_TABLE_DEPTH - 1) : q_div3[IDX_W-1:0];
      S_LUT:    target_r <= gated_r ? UNITY_GAIN : GAIN_TABLE[idx_r];
      S_SMOOTH: sprod_r  <= signed'({1'b0, c_cl}) * gdiff;
      default: begin
      end
    endcase

    if (out_load) begin
      out_band_r       <= band_r;
      out_band_error_r <= err_r;
      out_gain_r       <= err_r ? 16'd0 : wb_gain;
      out_floor_r      <= err_r ? 18'sd0 : wb_floor;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_band_out        = out_band_r;
  assign out_gate_gain       = out_gain_r;
  assign out_noise_floor_out = out_floor_r;
  assign out_band_error      = out_band_error_r;

  // ---- checks ----
  `MNGG_ASSERT_NXT(a_accept_starts_read, accept, state_r == S_RD)
  `MNGG_ASSERT_NXT(a_write_marks_band, ram_we, valid_r[band_r])
  `MNGG_ASSERT_IMP(a_result_from_wb, $rose(out_valid_r), $past(state_r == S_WB))
  `MNGG_ASSERT_IMP(a_error_zeroed, out_valid_r && out_band_error_r,
                   out_gain_r == 16'd0 && out_floor_r == 18'sd0)
  `MNGG_ASSERT_IMP(a_gain_le_unity, out_valid_r, out_gain_r <= UNITY_GAIN)

endmodule

// ===== rtl/core/mngg_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mngg_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module mngg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/mngg_cfg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mngg_cfg
// apb register file holding the gate settings
// ---------------------------------------------------------------------------
module mngg_cfg
  import mngg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_NUM_BANDS: cfg_nxt.num_bands     = pwdata[6:0];
        REG_THRESHOLD: cfg_nxt.threshold_db  = signed'(pwdata[14:0]);
        REG_REDUCTION: cfg_nxt.reduction_db  = signed'(pwdata[15:0]);
        REG_ALPHA:     cfg_nxt.noise_alpha   = pwdata[16:0];
        REG_ATTACK:    cfg_nxt.attack_coeff  = pwdata[16:0];
        REG_RELEASE:   cfg_nxt.release_coeff = pwdata[16:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NUM_BANDS: prdata = {25'd0, cfg_r.num_bands};
      REG_THRESHOLD: prdata = {17'd0, cfg_r.threshold_db};
      REG_REDUCTION: prdata = {16'd0, cfg_r.reduction_db};
      REG_ALPHA:     prdata = {15'd0, cfg_r.noise_alpha};
      REG_ATTACK:    prdata = {15'd0, cfg_r.attack_coeff};
      REG_RELEASE:   prdata = {15'd0, cfg_r.release_coeff};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_bands     <= NUM_BANDS_RST;
      cfg_r.threshold_db  <= THRESH_RST;
      cfg_r.reduction_db  <= REDUCT_RST;
      cfg_r.noise_alpha   <= ALPHA_RST;
      cfg_r.attack_coeff  <= ATTACK_RST;
      cfg_r.release_coeff <= RELEASE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
